// ===== rtl/fvc_pkg.sv =====
package fvc_pkg;

    localparam int ANG_W = 40;
    localparam int WHEEL_SIZE = 55;
    localparam int REG_WIDTH = 0;
    localparam int REG_HEIGHT = 1;

    localparam logic [23:0][20:0] ATAN_TABLE = {
        21'd0, 21'd0, 21'd0, 21'd0, 21'd1, 21'd1, 21'd3, 21'd5,
        21'd10, 21'd20, 21'd41, 21'd81, 21'd163, 21'd326, 21'd652, 21'd1304,
        21'd2608, 21'd5215, 21'd10427, 21'd20834, 21'd41506, 21'd81767, 21'd154753,
        21'd262144
    };

    typedef struct packed {
        logic signed [ANG_W-1:0] x;
        logic signed [ANG_W-1:0] y;
        logic signed [22:0]      z;
    } cordic_t;

    function automatic logic [23:0] wheel_rgb(input logic [5:0] k);
        int j;
        int r;
        int g;
        int b;
        j = int'(k);
        r = 0;
        g = 0;
        b = 0;
        if (j < 15) begin
            r = 255; g = (255 * j) / 15;
        end else if (j < 21) begin
            r = 255 - (255 * (j - 15)) / 6; g = 255;
        end else if (j < 25) begin
            g = 255; b = (255 * (j - 21)) / 4;
        end else if (j < 36) begin
            g = 255 - (255 * (j - 25)) / 11; b = 255;
        end else if (j < 49) begin
            b = 255; r = (255 * (j - 36)) / 13;
        end else if (j < 55) begin
            b = 255 - (255 * (j - 49)) / 6; r = 255;
        end
        return {r[7:0], g[7:0], b[7:0]};
    endfunction

    // wheel entries evaluated once at elaboration
    function automatic logic [WHEEL_SIZE-1:0][23:0] build_wheel();
        logic [WHEEL_SIZE-1:0][23:0] rom;
        for (int k = 0; k < WHEEL_SIZE; k++)
            rom[k] = wheel_rgb(6'(k));
        return rom;
    endfunction

    localparam logic [WHEEL_SIZE-1:0][23:0] WHEEL_ROM = build_wheel();

endpackage

// ===== rtl/fvc_cordic_cell.sv =====
// One rotation step of the angle chain.
module fvc_cordic_cell
    import fvc_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  cordic_t in_data,
    output logic    out_valid,
    output cordic_t out_data
);

    cordic_t next_data;
    logic    valid_reg;
    cordic_t data_reg;

    always_comb
    begin
        logic signed [ANG_W-1:0] xs;
        logic signed [ANG_W-1:0] ys;
        logic signed [22:0]      at;
        xs = in_data.x >>> STAGE;
        ys = in_data.y >>> STAGE;
        at = 23'(ATAN_TABLE[STAGE]);
        if (!in_data.y[ANG_W-1]) begin
            next_data.x = in_data.x + ys;
            next_data.y = in_data.y - xs;
            next_data.z = in_data.z + at;
        end else begin
            next_data.x = in_data.x - ys;
            next_data.y = in_data.y + xs;
            next_data.z = in_data.z - at;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) valid_reg <= 1'b0;
        else        valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= next_data;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/fvc_sqrt_cell.sv =====
// One result bit of the restoring square root (two bits of radicand per cell).
module fvc_sqrt_cell #(
    parameter int RW = 64,
    parameter int QW = 32
) (
    input  logic          clk,
    input  logic [RW-1:0] in_rem,
    input  logic [QW-1:0] in_root,
    input  logic [RW-1:0] in_rad,
    output logic [RW-1:0] out_rem,
    output logic [QW-1:0] out_root,
    output logic [RW-1:0] out_rad
);

    logic [RW+1:0] rem_sh;
    logic [RW+1:0] trial;
    logic [RW-1:0] rem_reg;
    logic [QW-1:0] root_reg;
    logic [RW-1:0] rad_reg;

    assign rem_sh = {in_rem, in_rad[RW-1:RW-2]};
    assign trial  = {in_root, 2'b01};

    always_ff @(posedge clk)
    begin
        if (rem_sh >= trial) begin
            rem_reg  <= RW'(rem_sh - trial);
            root_reg <= {in_root[QW-2:0], 1'b1};
        end else begin
            rem_reg  <= RW'(rem_sh);
            root_reg <= {in_root[QW-2:0], 1'b0};
        end
        rad_reg  <= {in_rad[RW-3:0], 2'b00};
    end

    assign out_rem  = rem_reg;
    assign out_root = root_reg;
    assign out_rad  = rad_reg;

endmodule

// ===== rtl/fvc_div_cell.sv =====
// One quotient bit of the restoring divider.
module fvc_div_cell #(
    parameter int NW = 58,
    parameter int DW = 34
) (
    input  logic          clk,
    input  logic [DW:0]   in_rem,
    input  logic [NW-1:0] in_num,
    input  logic [DW-1:0] in_den,
    output logic [DW:0]   out_rem,
    output logic [NW-1:0] out_num,
    output logic [DW-1:0] out_den
);

    logic [DW+1:0] sh;
    logic [DW:0]   rem_reg;
    logic [NW-1:0] num_reg;
    logic [DW-1:0] den_reg;

    assign sh = {in_rem, in_num[NW-1]};

    always_ff @(posedge clk)
    begin
        if (sh >= {2'b00, in_den}) begin
            rem_reg <= (DW+1)'(sh - {2'b00, in_den});
            num_reg <= {in_num[NW-2:0], 1'b1};
        end else begin
            rem_reg <= (DW+1)'(sh);
            num_reg <= {in_num[NW-2:0], 1'b0};
        end
        den_reg <= in_den;
    end

    assign out_rem = rem_reg;
    assign out_num = num_reg;
    assign out_den = den_reg;

endmodule

// ===== rtl/flow_vector_to_colour_unit.sv =====
// Fully pipelined: one vector per clock, one colour per clock, never stalls.
// Pipeline: after the capture stage come 58 divider cells,
// 29 square root cells and 4 wheel/mix/fade stages. The angle chain of
// CORDIC_STAGES cells (at most 24) runs beside it and is padded to match.
// busy is always low; the receiver cannot stall, a result strobe lasts one cycle.
// rst_n clears all valid bits and sets both image sizes to 1024.
module flow_vector_to_colour_unit
    import fvc_pkg::*;
#(
    parameter int MAX_DIM = 4096,
    parameter int CORDIC_STAGES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [12:0] shift_x,
    input  logic signed [12:0] shift_y,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [12:0]        cfg_data,
    output logic               strobe,
    output logic [7:0]         red,
    output logic [7:0]         green,
    output logic [7:0]         blue
);

    localparam int MD_W  = $clog2(MAX_DIM + 1);
    localparam int DEN_W = 2 * MD_W + 1;
    localparam int NUM_W = 58;
    localparam int RAD_W = 64;
    localparam int QW    = 32;
    localparam int NSQ   = 29;
    localparam int DLAT  = NUM_W + NSQ;
    localparam int NCELL = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;

    logic [12:0] width_reg;
    logic [12:0] height_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            width_reg  <= 13'd1024;
            height_reg <= 13'd1024;
        end else if (cfg_valid) begin
            if (cfg_index == 1'(REG_WIDTH)) width_reg  <= cfg_data;
            else                            height_reg <= cfg_data;
        end
    end

    function automatic logic [MD_W-1:0] eff_dim(input logic [12:0] d);
        if (d == 13'd0) return MD_W'(1);
        if (32'(d) > MAX_DIM) return MD_W'(MAX_DIM);
        return MD_W'(d);
    endfunction

    // stage 0: capture, squares
    logic               v0_reg;
    logic signed [13:0] u0_reg;
    logic signed [13:0] w0_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [25:0]        mag_next;
    logic [25:0]        mag_reg;
    logic [MD_W-1:0]    ew;
    logic [MD_W-1:0]    eh;

    assign ew = eff_dim(width_reg);
    assign eh = eff_dim(height_reg);
    assign mag_next = 26'(shift_x) * 26'(shift_x) + 26'(shift_y) * 26'(shift_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v0_reg <= 1'b0;
        else        v0_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        u0_reg  <= -14'(shift_x);
        w0_reg  <= -14'(shift_y);
        mag_reg <= mag_next;
        den_reg <= DEN_W'(ew) * DEN_W'(ew) + DEN_W'(eh) * DEN_W'(eh);
    end

    // divider chain: floor(mag * 2^32 / den), quotient ends in d_num
    logic [DEN_W:0]   d_rem  [NUM_W+1];
    logic [NUM_W-1:0] d_num  [NUM_W+1];
    logic [DEN_W-1:0] d_den  [NUM_W+1];

    assign d_rem[0] = '0;
    assign d_num[0] = {mag_reg, 32'd0};
    assign d_den[0] = den_reg;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_W; gi++) begin : g_div
            fvc_div_cell #(.NW(NUM_W), .DW(DEN_W)) u_cell (
                .clk     (clk),
                .in_rem  (d_rem[gi]),
                .in_num  (d_num[gi]),
                .in_den  (d_den[gi]),
                .out_rem (d_rem[gi+1]),
                .out_num (d_num[gi+1]),
                .out_den (d_den[gi+1])
            );
        end
    endgenerate

    // square root chain
    logic [RAD_W-1:0] s_rem  [NSQ+1];
    logic [QW-1:0]    s_root [NSQ+1];
    logic [RAD_W-1:0] s_rad  [NSQ+1];

    assign s_rem[0]  = '0;
    assign s_root[0] = '0;
    assign s_rad[0]  = {{(RAD_W-NUM_W){1'b0}}, d_num[NUM_W]} << (RAD_W - 2 * NSQ);

    generate
        for (gi = 0; gi < NSQ; gi++) begin : g_sqrt
            fvc_sqrt_cell #(.RW(RAD_W), .QW(QW)) u_cell (
                .clk      (clk),
                .in_rem   (s_rem[gi]),
                .in_root  (s_root[gi]),
                .in_rad   (s_rad[gi]),
                .out_rem  (s_rem[gi+1]),
                .out_root (s_root[gi+1]),
                .out_rad  (s_rad[gi+1])
            );
        end
    endgenerate

    // CORDIC chain on (-u,-v)
    cordic_t            c_data  [NCELL+1];
    logic               c_valid [NCELL+1];
    logic               c_y0    [NCELL+1];
    logic               c_x0    [NCELL+1];
    logic signed [13:0] c_u     [NCELL+1];
    logic signed [13:0] c_w     [NCELL+1];
    logic signed [22:0] off;
    cordic_t            c_first;

    always_comb
    begin
        c_first.x = u0_reg[13] ? ANG_W'(-u0_reg) <<< 16 : ANG_W'(u0_reg) <<< 16;
        c_first.y = u0_reg[13] ? ANG_W'(-w0_reg) <<< 16 : ANG_W'(w0_reg) <<< 16;
        c_first.z = '0;
        if (!u0_reg[13])    off = 23'sd0;
        else if (w0_reg > 0) off = 23'sd1048576;
        else                 off = -23'sd1048576;
    end

    assign c_data[0]  = c_first;
    assign c_valid[0] = v0_reg;
    assign c_y0[0] = (w0_reg == 14'sd0);
    assign c_x0[0] = (u0_reg == 14'sd0);
    assign c_u[0]  = u0_reg;
    assign c_w[0]  = w0_reg;

    logic signed [22:0] c_off [NCELL+1];
    assign c_off[0] = off;

    generate
        for (gi = 0; gi < NCELL; gi++) begin : g_cordic
            fvc_cordic_cell #(.STAGE(gi)) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (c_valid[gi]),
                .in_data   (c_data[gi]),
                .out_valid (c_valid[gi+1]),
                .out_data  (c_data[gi+1])
            );
            always_ff @(posedge clk)
            begin
                c_y0[gi+1]  <= c_y0[gi];
                c_x0[gi+1]  <= c_x0[gi];
                c_u[gi+1]   <= c_u[gi];
                c_w[gi+1]   <= c_w[gi];
                c_off[gi+1] <= c_off[gi];
            end
        end
    endgenerate

    // final angle, then delay line to align with the norm
    logic signed [22:0] ang;
    logic signed [23:0] asum;
    always_comb
    begin
        asum = 24'(c_off[NCELL]) + 24'(c_data[NCELL].z);
        if (c_y0[NCELL])
            ang = (c_u[NCELL] > 0) ? 23'sd0 : -23'sd1048576;
        else if (c_x0[NCELL])
            ang = (c_w[NCELL] > 0) ? 23'sd524288 : -23'sd524288;
        else if (asum > 24'sd1048576)
            ang = 23'sd1048576;
        else if (asum < -24'sd1048576)
            ang = -23'sd1048576;
        else
            ang = 23'(asum);
    end

    localparam int ADLY = DLAT - NCELL;
    logic        v_line [ADLY+1];
    logic [21:0] apos;
    assign apos = 22'(24'(ang) + 24'sd1048576);

    // apos fits 0..2^21; store as 22 bits
    logic [21:0] ap_line [ADLY+1];
    assign ap_line[0] = apos;
    assign v_line[0]  = c_valid[NCELL];

    generate
        for (gi = 0; gi < ADLY; gi++) begin : g_adly
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n) v_line[gi+1] <= 1'b0;
                else        v_line[gi+1] <= v_line[gi];
            end
            always_ff @(posedge clk)
            begin
                ap_line[gi+1] <= ap_line[gi];
            end
        end
    endgenerate

    // wheel stage 1: S = apos*54, indices
    logic        v1_reg;
    logic [27:0] s1_reg;
    logic [28:0] n1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v1_reg <= 1'b0;
        else        v1_reg <= v_line[ADLY];
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= 28'(ap_line[ADLY]) * 28'd54;
        n1_reg <= 29'(s_root[NSQ]);
    end

    logic [5:0] k0;
    logic [5:0] k1;
    logic [20:0] fr;
    always_comb
    begin
        k0 = 6'(s1_reg[27:21]) + 6'd1;
        k1 = k0 + 6'd1;
        if (k0 > 6'(WHEEL_SIZE - 1)) k0 = 6'(WHEEL_SIZE - 1);
        if (k1 > 6'(WHEEL_SIZE - 1)) k1 = 6'(WHEEL_SIZE - 1);
        fr = s1_reg[20:0];
    end

    // stage 2: mix
    logic        v2_reg;
    logic [28:0] n2_reg;
    logic [28:0] c2_reg [3];
    logic [23:0] rgb0;
    logic [23:0] rgb1;
    assign rgb0 = WHEEL_ROM[k0];
    assign rgb1 = WHEEL_ROM[k1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v2_reg <= 1'b0;
        else        v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        n2_reg <= n1_reg;
        for (int ch = 0; ch < 3; ch++)
            c2_reg[ch] <= 29'(rgb0[23-8*ch -: 8]) * 29'(22'h200000 - 22'(fr))
                        + 29'(rgb1[23-8*ch -: 8]) * 29'(fr);
    end

    // stage 3: P = norm*(255*2^21 - C)
    logic        v3_reg;
    logic [56:0] p3_reg [3];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v3_reg <= 1'b0;
        else        v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int ch = 0; ch < 3; ch++)
            p3_reg[ch] <= 57'(n2_reg) * 57'(29'd534773760 - c2_reg[ch]);
    end

    // stage 4: fade and round
    logic [56:0] lim;
    assign lim = 57'd255 << 37;
    logic       v4_reg;
    logic [7:0] o_reg [3];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v4_reg <= 1'b0;
        else        v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int ch = 0; ch < 3; ch++) begin
            logic [46:0] t;
            t = 47'(lim - p3_reg[ch]) + (47'd1 << 36);
            if (p3_reg[ch] >= lim) o_reg[ch] <= 8'd0;
            else if (t[46:37] > 10'd255) o_reg[ch] <= 8'd255;
            else o_reg[ch] <= t[44:37];
        end
    end

    assign strobe = v4_reg;
    assign red    = o_reg[0];
    assign green  = o_reg[1];
    assign blue   = o_reg[2];

endmodule
